>>> hdl/fae_pkg.sv
// Shared types, codes and constants for the frame auto-exposure controller.
// No dependencies; imported by fae_div and frame_auto_exposure_controller.
package fae_pkg;

    localparam int MAX_FRAME_PIXELS_DEF    = 4194304;
    localparam int RATIO_FRACTION_BITS_DEF = 8;

    localparam int RATIO_W = 24;
    localparam int PCT_W   = 7;
    localparam int RATE_W  = 12;
    localparam int LFSR_W  = 16;
    localparam int PROD_W  = 32;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;

    // configuration register indexes
    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_TOLERANCE = 3'd1;
    localparam logic [2:0] REG_MAX_ITER  = 3'd2;
    localparam logic [2:0] REG_RATE      = 3'd3;
    localparam logic [2:0] REG_START_EXP = 3'd4;

    localparam logic [PCT_W-1:0]  TARGET_RST    = 7'd18;
    localparam logic [PCT_W-1:0]  TOLERANCE_RST = 7'd3;
    localparam logic [PCT_W-1:0]  MAX_ITER_RST  = 7'd6;
    localparam logic [RATE_W-1:0] RATE_RST      = 12'd30;
    localparam logic [PCT_W-1:0]  START_EXP_RST = 7'd50;

    // result status codes
    localparam logic [1:0] STAT_ADJUST    = 2'd0;
    localparam logic [1:0] STAT_CONVERGED = 2'd1;
    localparam logic [1:0] STAT_STUCK     = 2'd2;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_AFTER
    } phase_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_MEAN_START,
        SEQ_MEAN,
        SEQ_POST,
        SEQ_SECANT,
        SEQ_CHECK,
        SEQ_MUL,
        SEQ_APPLY,
        SEQ_UPDATE,
        SEQ_FIN
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hdl/fae_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fae_pkg (div_stat_t).
module fae_div
    import fae_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output div_stat_t     stat,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NW-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> hdl/frame_auto_exposure_controller.sv
// Frame auto-exposure controller: pixel accumulation, frame-end sequencer.
// Depends on fae_pkg and fae_div.
//
// Pixels and start beats are taken one per cycle while the sequencer is idle. A
// frame_end beat holds s_tready low while the sequencer runs the frame-end
// arithmetic. The mean goes through one shared serial divider (one quotient bit
// per cycle, NW = max(SUM_W, 24) bits), the percent scaling is a reciprocal
// shift-add, and a second division forms the secant ratio. The sequencer also
// waits while the previous result still sits in the output register. The result
// then sits in that register while pixels of the next frame are taken. Every
// sampling_rate-th pixel is summed using a running phase counter; change
// sampling_rate only between frames.
module frame_auto_exposure_controller
    import fae_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS    = MAX_FRAME_PIXELS_DEF,
    parameter int RATIO_FRACTION_BITS = RATIO_FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] action
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] exposure, [13:7] measured_intensity,
                                   // [15:14] status, [22:16] iteration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);

    localparam int F     = RATIO_FRACTION_BITS;
    localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int SUM_W = CNT_W + 8;
    localparam int NW    = (SUM_W > 24) ? SUM_W : 24;
    localparam int DW    = (CNT_W > 8) ? CNT_W : 8;

    // configuration
    logic [PCT_W-1:0]  target_reg, tol_reg, max_iter_reg, start_exp_reg;
    logic [RATE_W-1:0] rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RST;
            tol_reg       <= TOLERANCE_RST;
            max_iter_reg  <= MAX_ITER_RST;
            rate_reg      <= RATE_RST;
            start_exp_reg <= START_EXP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET:    target_reg    <= cfg_wdata[PCT_W-1:0];
                REG_TOLERANCE: tol_reg       <= cfg_wdata[PCT_W-1:0];
                REG_MAX_ITER:  max_iter_reg  <= cfg_wdata[PCT_W-1:0];
                REG_RATE:      rate_reg      <= cfg_wdata;
                REG_START_EXP: start_exp_reg <= cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // state
    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [PCT_W-1:0]  cur_reg, cur_next, last_i_reg, last_i_next;
    logic [PCT_W-1:0]  hist0_reg, hist0_next, hist1_reg, hist1_next;
    logic [1:0]        hc_reg, hc_next;
    logic [PCT_W-1:0]  adj_reg, adj_next;
    logic signed [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, grp_reg, grp_next;
    logic [RATE_W-1:0] samp_reg, samp_next;
    logic [PCT_W-1:0]  meas_reg, meas_next, nxt_reg, nxt_next;
    logic signed [7:0] dist_reg, dist_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic              retry_reg, retry_next, neg_reg, neg_next;
    logic [1:0]        status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_data_reg, m_data_next;

    // divider
    logic          div_start;
    logic [NW-1:0] div_dividend, div_quo;
    logic [DW-1:0] div_divisor;
    div_stat_t     div_stat;

    fae_div #(.NW(NW), .DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    logic [RATE_W-1:0] rate_eff;
    logic              acc_en, s_fire;
    logic signed [7:0] de, di, dist_c;
    logic [7:0]        abs_de, abs_di, abs_dist, avg_sum;
    logic signed [PROD_W-1:0] step;
    logic signed [PROD_W+1:0] sum_e;
    logic [PCT_W-1:0]  clamped, start_clamp;
    logic [LFSR_W-1:0] lfsr_adv;
    logic [14:0]       pct_x;
    logic [15:0]       pct_q;

    assign s_tready = (state_reg == SEQ_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign rate_eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
    assign acc_en   = (cnt_reg < CNT_W'(MAX_FRAME_PIXELS));
    assign start_clamp = (start_exp_reg > PCT_FULL) ? PCT_FULL : start_exp_reg;

    assign de     = $signed({1'b0, hist0_reg}) - $signed({1'b0, cur_reg});
    assign di     = $signed({1'b0, last_i_reg}) - $signed({1'b0, meas_reg});
    assign abs_de = de[7] ? 8'(-de) : 8'(de);
    assign abs_di = di[7] ? 8'(-di) : 8'(di);
    assign dist_c = $signed({1'b0, target_reg}) - $signed({1'b0, meas_reg});
    assign abs_dist = dist_c[7] ? 8'(-dist_c) : 8'(dist_c);

    // mean * 100 / 255 as (x + x / 256 + 1) / 256, exact for x below 65280
    assign pct_x = 15'(div_quo[7:0]) * 15'd100;
    assign pct_q = {1'b0, pct_x} + 16'(pct_x[14:8]) + 16'd1;

    // step = prod / 2^F rounded toward zero
    assign step  = (prod_reg + (prod_reg[PROD_W-1] ? PROD_W'((1 << F) - 1) : PROD_W'(0)))
                   >>> F;
    assign sum_e = $signed({{(PROD_W+2-PCT_W){1'b0}}, cur_reg}) + (PROD_W+2)'(step);
    assign clamped = sum_e[PROD_W+1] ? '0 :
                     (sum_e > (PROD_W+2)'(PCT_FULL)) ? PCT_FULL : sum_e[PCT_W-1:0];
    assign lfsr_adv = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                       lfsr_reg[LFSR_W-1:1]};
    assign avg_sum  = {1'b0, nxt_reg} + {1'b0, cur_reg};

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        last_i_next  = last_i_reg;
        hist0_next   = hist0_reg;
        hist1_next   = hist1_reg;
        hc_next      = hc_reg;
        adj_next     = adj_reg;
        ratio_next   = ratio_reg;
        lfsr_next    = lfsr_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        grp_next     = grp_reg;
        samp_next    = samp_reg;
        meas_next    = meas_reg;
        nxt_next     = nxt_reg;
        dist_next    = dist_reg;
        prod_next    = prod_reg;
        retry_next   = retry_reg;
        neg_next     = neg_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        case (state_reg)
            SEQ_IDLE: begin
                if (s_fire) begin
                    if (!s_tuser) begin
                        cur_next   = start_clamp;
                        ratio_next = RATIO_W'(1) <<< F;
                        hist0_next = start_clamp;
                        hist1_next = '0;
                        hc_next    = 2'd1;
                        adj_next   = '0;
                        sum_next   = '0;
                        cnt_next   = '0;
                        grp_next   = '0;
                        samp_next  = '0;
                        phase_next = PH_FIRST;
                    end else if (phase_reg != PH_IDLE) begin
                        if (acc_en) begin
                            if (samp_reg == '0) begin
                                sum_next = sum_reg + SUM_W'(s_tdata);
                            end
                            if (samp_reg == rate_eff - RATE_W'(1)) begin
                                samp_next = '0;
                                grp_next  = grp_reg + CNT_W'(1);
                            end else begin
                                samp_next = samp_reg + RATE_W'(1);
                            end
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        if (s_tlast) begin
                            cnt_next   = '0;
                            samp_next  = '0;
                            state_next = SEQ_MEAN_START;
                        end
                    end
                end
            end
            SEQ_MEAN_START: begin
                sum_next = '0;
                grp_next = '0;
                if (grp_reg == '0) begin
                    meas_next  = '0;
                    state_next = SEQ_POST;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = NW'(sum_reg);
                    div_divisor  = DW'(grp_reg);
                    state_next   = SEQ_MEAN;
                end
            end
            SEQ_MEAN: begin
                if (div_stat.done) begin
                    meas_next  = (div_quo[NW-1:8] != '0) ? PCT_FULL : pct_q[PCT_W+7:8];
                    state_next = SEQ_POST;
                end
            end
            SEQ_POST: begin
                last_i_next = meas_reg;
                state_next  = SEQ_CHECK;
                if (phase_reg == PH_AFTER) begin
                    if (di == 8'sd0) begin
                        ratio_next = RATIO_W'(de) <<< F;
                    end else begin
                        neg_next     = de[7] ^ di[7];
                        div_start    = 1'b1;
                        div_dividend = NW'(abs_de) << F;
                        div_divisor  = DW'(abs_di);
                        state_next   = SEQ_SECANT;
                    end
                end
            end
            SEQ_SECANT: begin
                if (div_stat.done) begin
                    ratio_next = neg_reg ? -$signed(div_quo[RATIO_W-1:0])
                                         : $signed(div_quo[RATIO_W-1:0]);
                    state_next = SEQ_CHECK;
                end
            end
            SEQ_CHECK: begin
                dist_next = dist_c;
                if (abs_dist <= {1'b0, tol_reg}) begin
                    status_next = STAT_CONVERGED;
                    phase_next  = PH_IDLE;
                    state_next  = SEQ_FIN;
                end else if (adj_reg >= max_iter_reg) begin
                    status_next = STAT_EXHAUSTED;
                    phase_next  = PH_IDLE;
                    state_next  = SEQ_FIN;
                end else begin
                    retry_next = 1'b0;
                    state_next = SEQ_MUL;
                end
            end
            SEQ_MUL: begin
                prod_next  = PROD_W'(dist_reg) * PROD_W'(ratio_reg);
                state_next = SEQ_APPLY;
            end
            SEQ_APPLY: begin
                if (!retry_reg && clamped == cur_reg) begin
                    if (cur_reg == '0 || cur_reg == PCT_FULL) begin
                        status_next = STAT_STUCK;
                        phase_next  = PH_IDLE;
                        state_next  = SEQ_FIN;
                    end else begin
                        // retry with ratio 3 plus a random fraction
                        lfsr_next  = lfsr_adv;
                        ratio_next = (RATIO_W'(3) <<< F)
                                     + RATIO_W'(lfsr_adv >> (LFSR_W - F));
                        retry_next = 1'b1;
                        state_next = SEQ_MUL;
                    end
                end else begin
                    nxt_next   = clamped;
                    state_next = SEQ_UPDATE;
                end
            end
            SEQ_UPDATE: begin
                if (hc_reg > 2'd1) begin
                    cur_next   = (nxt_reg == hist0_reg) ? avg_sum[PCT_W:1] : nxt_reg;
                    hist0_next = hist1_reg;
                    hist1_next = (nxt_reg == hist0_reg) ? avg_sum[PCT_W:1] : nxt_reg;
                end else begin
                    cur_next   = nxt_reg;
                    hist1_next = nxt_reg;
                end
                hc_next     = 2'd2;
                adj_next    = adj_reg + PCT_W'(1);
                status_next = STAT_ADJUST;
                phase_next  = PH_AFTER;
                state_next  = SEQ_FIN;
            end
            SEQ_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, adj_reg, status_reg, meas_reg, cur_reg};
                    state_next   = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            phase_reg   <= PH_IDLE;
            cur_reg     <= '0;
            last_i_reg  <= '0;
            hist0_reg   <= '0;
            hist1_reg   <= '0;
            hc_reg      <= '0;
            adj_reg     <= '0;
            ratio_reg   <= RATIO_W'(1) <<< F;
            lfsr_reg    <= LFSR_SEED;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            grp_reg     <= '0;
            samp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            last_i_reg  <= last_i_next;
            hist0_reg   <= hist0_next;
            hist1_reg   <= hist1_next;
            hc_reg      <= hc_next;
            adj_reg     <= adj_next;
            ratio_reg   <= ratio_next;
            lfsr_reg    <= lfsr_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            grp_reg     <= grp_next;
            samp_reg    <= samp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        meas_reg   <= meas_next;
        nxt_reg    <= nxt_next;
        dist_reg   <= dist_next;
        prod_reg   <= prod_next;
        retry_reg  <= retry_next;
        neg_reg    <= neg_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_exp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= PCT_FULL && m_tdata[13:7] <= PCT_FULL))
        else $error("exposure or intensity out of range");

    a_adj_iter: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] == STAT_ADJUST) |-> (m_tdata[22:16] != '0))
        else $error("adjust result without an iteration");

    a_busy_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == SEQ_MEAN || state_reg == SEQ_SECANT))
        else $error("divider running outside a divide state");

endmodule

>>> tb/frame_auto_exposure_controller_test.sv
// Self-checking testbench for frame_auto_exposure_controller: drives start and
// pixel beats, predicts every frame-end result and checks it per field.
// Depends on fae_pkg and the controller RTL.
module frame_auto_exposure_controller_test;
    import fae_pkg::*;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;
    localparam int   FRAC       = RATIO_FRACTION_BITS_DEF;
    localparam int   RATIO_HI   = 8388607;
    localparam int   RATIO_LO   = -8388608;
    localparam int   SETTLE     = 300;
    localparam int   IDLE_LIMIT = 3000;
    localparam int   ITEM_GOAL  = 700;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic [6:0] iteration;
        logic [1:0] status;
        logic [6:0] intensity;
        logic [6:0] exposure;
    } ae_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_wdata;

    frame_auto_exposure_controller u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predicted configuration and state
    int         cfg_target   = TARGET_RST;
    int         cfg_tol      = TOLERANCE_RST;
    int         cfg_max_iter = MAX_ITER_RST;
    int         cfg_rate     = RATE_RST;
    int         cfg_start    = START_EXP_RST;
    int         cur_exp      = 0;
    int         last_int     = 0;
    int         ratio        = 1 << FRAC;
    int         hist[2]      = '{0, 0};
    int         hcount       = 0;
    int         adj          = 0;
    longint     psum         = 0;
    int         pcount       = 0;
    phase_t     phase        = PH_IDLE;
    logic [15:0] lfsr        = LFSR_SEED;

    ae_result_t pending_results[$];
    int         errors  = 0;
    int         n_items = 0;
    bit         quiet   = 0;
    int         idle_cycles = 0;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int clamp_pct(longint v);
        return (v < 0) ? 0 : (v > 100) ? 100 : int'(v);
    endfunction

    function automatic int sat24(longint v);
        return (v > RATIO_HI) ? RATIO_HI : (v < RATIO_LO) ? RATIO_LO : int'(v);
    endfunction

    function int adjusted_exposure(int base, int diff);
        longint prod;
        prod = longint'(diff) * longint'(ratio);
        return clamp_pct(longint'(base) + prod / (64'sd1 << FRAC));
    endfunction

    function int frame_pct(int rate);
        int     groups;
        longint mean;
        longint pct;
        groups = pcount / rate;
        if (groups == 0) return 0;
        mean = psum / groups;
        pct = mean * 100 / 255;
        return (pct > 100) ? 100 : int'(pct);
    endfunction

    function void predict_beat(logic act, logic [7:0] pix, logic fend);
        int         rate, meas, err, old, nxt, stat, frac;
        longint     de, di, num;
        ae_result_t r;
        rate = (cfg_rate == 0) ? 1 : cfg_rate;
        if (act == ACT_START) begin
            cur_exp = clamp_pct(cfg_start);
            ratio = 1 << FRAC;
            hist[0] = cur_exp;
            hist[1] = 0;
            hcount = 1;
            adj = 0;
            psum = 0;
            pcount = 0;
            phase = PH_FIRST;
            return;
        end
        if (phase == PH_IDLE) return;
        if (pcount < MAX_FRAME_PIXELS_DEF) begin
            if (pcount % rate == 0) psum += pix;
            pcount++;
        end
        if (!fend) return;
        meas = frame_pct(rate);
        psum = 0;
        pcount = 0;
        if (phase == PH_AFTER) begin
            de = hist[0] - cur_exp;
            di = last_int - meas;
            num = de * (64'sd1 << FRAC);
            ratio = sat24(di == 0 ? num : num / di);
        end
        last_int = meas;
        err = cfg_target - meas;
        if ((err < 0 ? -err : err) <= cfg_tol) begin
            stat = STAT_CONVERGED;
            phase = PH_IDLE;
        end else if (adj >= cfg_max_iter) begin
            stat = STAT_EXHAUSTED;
            phase = PH_IDLE;
        end else begin
            old = cur_exp;
            nxt = adjusted_exposure(old, err);
            stat = STAT_ADJUST;
            if (nxt == old) begin
                if (old == 0 || old == 100) begin
                    stat = STAT_STUCK;
                    phase = PH_IDLE;
                end else begin
                    // no progress: reseed the ratio with 3 plus a random fraction
                    lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                    frac = int'(lfsr >> (16 - FRAC));
                    ratio = sat24((64'sd3 << FRAC) + frac);
                    nxt = adjusted_exposure(old, err);
                end
            end
            if (stat == STAT_ADJUST) begin
                if (hcount > 1) begin
                    if (nxt == hist[0]) nxt = (nxt + old) / 2;
                    hist[0] = hist[1];
                    hcount = 1;
                end
                hist[hcount & 1] = nxt;
                hcount++;
                cur_exp = nxt;
                adj = (adj + 1) & 127;
                phase = PH_AFTER;
            end
        end
        r.exposure = cur_exp[6:0];
        r.intensity = meas[6:0];
        r.status = stat[1:0];
        r.iteration = adj[6:0];
        pending_results = {pending_results, r};
    endfunction

    task automatic send_beat(logic act, logic [7:0] pix, logic fend);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= pix;
        s_tlast <= fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(act, pix, fend);
        n_items++;
    endtask

    task automatic send_frame(int len, int level);
        int pix;
        for (int i = 0; i < len; i++) begin
            pix = level + int'($urandom_range(0, 31)) - 16;
            pix = (pix < 0) ? 0 : (pix > 255) ? 255 : pix;
            send_beat(ACT_PIXEL, pix[7:0], i == len - 1);
        end
    endtask

    // hold the input until every result is back, then let the sequencer settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[11:0];
        @(posedge aclk);
        case (idx)
            REG_TARGET:    cfg_target   = value & 8'h7F;
            REG_TOLERANCE: cfg_tol      = value & 8'h7F;
            REG_MAX_ITER:  cfg_max_iter = value & 8'h7F;
            REG_RATE:      cfg_rate     = value & 12'hFFF;
            REG_START_EXP: cfg_start    = value & 8'h7F;
            default: ;
        endcase
    endtask

    task automatic set_config(int tgt, int tol, int max_it, int rate, int start_exp);
        drain();
        write_reg(REG_TARGET, tgt);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_MAX_ITER, max_it);
        write_reg(REG_RATE, rate);
        write_reg(REG_START_EXP, start_exp);
        write_reg(REG_UNUSED, $urandom_range(0, 4095));
        cfg_we <= 1'b0;
    endtask

    task automatic test_idle_pixels();
        send_beat(ACT_PIXEL, 8'hFF, 1'b0);
        send_beat(ACT_PIXEL, 8'h00, 1'b1);
        send_beat(ACT_PIXEL, 8'hA5, 1'b1);
    endtask

    task automatic test_default_session();
        send_beat(ACT_START, 8'h00, 1'b0);
        send_frame(40, 60);
        send_frame(40, 40);
    endtask

    task automatic test_extremes();
        // zero iteration budget on a saturated frame, clamped start exposure
        set_config(0, 0, 0, 1, 127);
        send_beat(ACT_START, 8'hFF, 1'b1);
        send_frame(2, 255);
        // zero rate, widest tolerance
        set_config(100, 100, 64, 0, 0);
        send_beat(ACT_START, 8'h00, 1'b0);
        send_frame(1, 0);
        // frames shorter than the rate read as black; full exposure sticks
        set_config(100, 0, 64, 4095, 100);
        send_beat(ACT_START, 8'h00, 1'b0);
        send_frame(3, 200);
        // restart right after a frame
        send_beat(ACT_START, 8'h00, 1'b0);
        send_frame(2, 128);
        send_beat(ACT_START, 8'h00, 1'b0);
        send_frame(2, 255);
    endtask

    function automatic int pick(int lo, int hi, int typ_lo, int typ_hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return $urandom_range(typ_lo, typ_hi);
        endcase
    endfunction

    task automatic test_random_sessions();
        int gain, frames, level, len, rate;
        while (n_items < ITEM_GOAL + 25) begin
            rate = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(1, 6);
            set_config(pick(0, 100, 5, 60), pick(0, 100, 0, 6), pick(0, 64, 1, 10),
                       rate, pick(0, 127, 0, 100));
            quiet = ($urandom_range(0, 3) == 0);
            gain = $urandom_range(2, 40);
            send_beat(ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            frames = $urandom_range(1, 12);
            for (int f = 0; f < frames && phase != PH_IDLE; f++) begin
                level = (cur_exp * gain) / 8;
                if ($urandom_range(0, 9) == 0) level = $urandom_range(0, 255);
                len = $urandom_range(1, 40);
                if ($urandom_range(0, 11) == 0) begin
                    send_frame($urandom_range(1, 5), level);
                    send_beat(ACT_START, 8'h00, 1'b0);
                end
                send_frame(len, level > 255 ? 255 : level);
            end
            // noise after the session
            if ($urandom_range(0, 5) == 0) send_frame($urandom_range(1, 6), $urandom_range(0, 255));
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= ACT_PIXEL;
        s_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_TARGET;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_pixels();
        test_default_session();
        test_extremes();
        test_random_sessions();
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_checker
        ae_result_t exp_r, got_r;
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && aresetn)) @(posedge aclk);
            got_r = m_tdata[22:0];
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got_r.exposure !== exp_r.exposure) begin
                    $error("exposure: expected %0d, got %0d", exp_r.exposure, got_r.exposure);
                    errors++;
                end
                if (got_r.intensity !== exp_r.intensity) begin
                    $error("measured_intensity: expected %0d, got %0d",
                           exp_r.intensity, got_r.intensity);
                    errors++;
                end
                if (got_r.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
                    errors++;
                end
                if (got_r.iteration !== exp_r.iteration) begin
                    $error("iteration: expected %0d, got %0d",
                           exp_r.iteration, got_r.iteration);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
